// File: rtl/evec_pkg.sv
// Shared types, constants and helpers for the 3x3 eigenvector unit.
package evec_pkg;

  localparam int FracBits  = 16;
  localparam int TolWidth  = 16;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam int FrontLat  = 13;
  localparam int Latency   = FrontLat + SqrtSteps + 1 + DivSteps + 1;
  localparam int AddrWidth = 3;

  typedef enum logic [1:0] {
    StNormal = 2'd0,
    StDiag   = 2'd1,
    StDegen  = 2'd2
  } status_e;

  typedef enum logic {
    RegZeroTol = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] eigen_value;
  } evec_in_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    status_e            status;
  } evec_out_t;

  // tolerance register is Q0.16; align to FracBits
  function automatic logic [32:0] tol_align(input logic [TolWidth-1:0] t);
    logic [32:0] r;
    if (FracBits >= 16) r = 33'(t) << (FracBits - 16);
    else                r = 33'(t) >> (16 - FracBits);
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return e[32] ? 33'(-e) : 33'(e);
  endfunction

  // symmetric saturation to [-(2^31-1), 2^31-1]
  function automatic logic signed [31:0] sat_l(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -33'sd2147483647) r = 32'sh80000001;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/evec_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module evec_div_pipe import evec_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [63:0]         num_i,
  input  logic [31:0]         den_i,
  output logic [DivSteps-1:0] quo_o
);

  logic [63:0]         rem_q [DivSteps];
  logic [31:0]         den_q [DivSteps];
  logic [DivSteps-1:0] quo_q [DivSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    localparam int B = DivSteps - 1 - g;
    logic [63:0]         r_in;
    logic [31:0]         d_in;
    logic [DivSteps-1:0] q_in;
    logic [63:0]         dsh;
    logic                take;

    if (g == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem_q[g-1];
      assign d_in = den_q[g-1];
      assign q_in = quo_q[g-1];
    end

    assign dsh  = {32'd0, d_in} << B;
    assign take = (r_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= take ? (r_in - dsh) : r_in;
        den_q[g] <= d_in;
        quo_q[g] <= q_in | (DivSteps'(take) << B);
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

// File: rtl/eigenvector_from_eigenvalue_3x3_unit.sv
// Top level: unit eigenvector of a 3x3 matrix by the cross-product method.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (evec_in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (evec_out_t)
//   cfg      APB slave  psel/penable/pwrite       zero_tolerance at byte 0
//
// One transfer per cycle while the output is not stalled; the stages are 13 front
// stages, 32 square-root stages, 1 numerator stage, 31 divider stages and output.
// The whole pipeline advances together; it holds only while the output
// register has a result that is stalled, so in_stall_o follows that condition.
// Reset clears the valid bits and the tolerance register (to zero).
module eigenvector_from_eigenvalue_3x3_unit import evec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  evec_in_t             in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output evec_out_t            out_data_o,
  input  logic                 out_stall_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // ---------------------------------------------------------------- config
  logic [TolWidth-1:0] tol_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite &&
                 reg_idx_e'(paddr[2]) == RegZeroTol) begin
      tol_q <= pwdata[TolWidth-1:0];
    end
  end

  assign prdata = (reg_idx_e'(paddr[2]) == RegZeroTol) ? {16'd0, tol_q} : 32'd0;

  // ---------------------------------------------------------------- control
  logic               en;
  logic [Latency:1]   v_q;

  assign in_stall_o  = v_q[Latency] && out_stall_i;
  assign en          = !in_stall_o;
  assign out_valid_o = v_q[Latency];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Latency-1:1], in_valid_i};
    end
  end

  // ------------------------------------------- s1: L = M - ev*I, diag test
  logic signed [31:0] m [3][3];
  logic signed [31:0] l_d [3][3];
  logic signed [31:0] l_q [3][3];
  logic               diag_d;
  logic [7:1]         dg_q;
  logic [32:0]        tol_al;

  assign m[0][0] = in_data_i.m00;
  assign m[0][1] = in_data_i.m01;
  assign m[0][2] = in_data_i.m02;
  assign m[1][0] = in_data_i.m10;
  assign m[1][1] = in_data_i.m11;
  assign m[1][2] = in_data_i.m12;
  assign m[2][0] = in_data_i.m20;
  assign m[2][1] = in_data_i.m21;
  assign m[2][2] = in_data_i.m22;
  assign tol_al  = tol_align(tol_q);

  always_comb begin
    diag_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == j) begin
          l_d[i][j] = sat_l({m[i][j][31], m[i][j]} -
                            {in_data_i.eigen_value[31], in_data_i.eigen_value});
        end else begin
          l_d[i][j] = sat_l({m[i][j][31], m[i][j]});
          if (mag33(m[i][j]) > tol_al) diag_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q  <= l_d;
      dg_q <= {dg_q[6:1], diag_d};
    end
  end

  // ------------------------ s2..s7: cross products and squared lengths
  logic signed [63:0] pa_q [3][3];
  logic signed [63:0] pb_q [3][3];
  logic signed [63:0] c_q  [3][3];
  logic [62:0]        mag4_q [3][3];
  logic [62:0]        mag5_q [3][3];
  logic [62:0]        mag6_q [3][3];
  logic [62:0]        mag7_q [3][3];
  logic               sg4_q [3][3];
  logic               sg5_q [3][3];
  logic               sg6_q [3][3];
  logic               sg7_q [3][3];
  logic [61:0]        hh_q [3][3];
  logic [62:0]        hl_q [3][3];
  logic [63:0]        ll_q [3][3];
  logic [127:0]       sq_q [3][3];
  logic [127:0]       len_q [3];

  // candidate k uses row pair (0,1), (0,2), (1,2)
  for (genvar k = 0; k < 3; k++) begin : g_cand
    localparam int RA = (k == 2) ? 1 : 0;
    localparam int RB = (k == 0) ? 1 : 2;
    for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J1 = (i + 1) % 3;
      localparam int J2 = (i + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (en) begin
          pa_q[k][i]   <= l_q[RA][J1] * l_q[RB][J2];
          pb_q[k][i]   <= l_q[RA][J2] * l_q[RB][J1];
          c_q[k][i]    <= pa_q[k][i] - pb_q[k][i];
          sg4_q[k][i]  <= c_q[k][i][63];
          mag4_q[k][i] <= c_q[k][i][63] ? 63'(-c_q[k][i]) : c_q[k][i][62:0];
          // square split into 32-bit partial products
          hh_q[k][i]   <= mag4_q[k][i][62:32] * mag4_q[k][i][62:32];
          hl_q[k][i]   <= mag4_q[k][i][62:32] * mag4_q[k][i][31:0];
          ll_q[k][i]   <= mag4_q[k][i][31:0] * mag4_q[k][i][31:0];
          sq_q[k][i]   <= ({66'd0, hh_q[k][i]} << 64) + ({65'd0, hl_q[k][i]} << 33)
                          + {64'd0, ll_q[k][i]};
          mag5_q[k][i] <= mag4_q[k][i];
          mag6_q[k][i] <= mag5_q[k][i];
          mag7_q[k][i] <= mag6_q[k][i];
          sg5_q[k][i]  <= sg4_q[k][i];
          sg6_q[k][i]  <= sg5_q[k][i];
          sg7_q[k][i]  <= sg6_q[k][i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        len_q[k] <= sq_q[k][0] + sq_q[k][1] + sq_q[k][2];
      end
    end
  end

  // ------------------------------ s8: pick the longest candidate
  logic [1:0]  sel;
  logic [62:0] mg8_q [3];
  logic        sg8_q [3];
  status_e     st8_q;
  status_e     st8_d;

  always_comb begin
    if (len_q[0] >= len_q[1]) sel = (len_q[0] >= len_q[2]) ? 2'd0 : 2'd2;
    else                      sel = (len_q[1] >= len_q[2]) ? 2'd1 : 2'd2;
    if (dg_q[7])                    st8_d = StDiag;
    else if (len_q[sel] == 128'd0)  st8_d = StDegen;
    else                            st8_d = StNormal;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mg8_q <= mag7_q[sel];
      sg8_q <= sg7_q[sel];
      st8_q <= st8_d;
    end
  end

  // ------------------------ s9..s11: scale largest into [2^30, 2^31)
  logic [62:0] mx9_q;
  logic [62:0] mg9_q [3];
  logic [62:0] mg10_q [3];
  logic        sg9_q [3];
  logic        sg10_q [3];
  logic        sg11_q [3];
  status_e     st9_q, st10_q, st11_q;
  logic [62:0] mx9_d;
  logic [5:0]  pos_d;
  logic [5:0]  pos10_q;
  logic [30:0] mg11_q [3];
  logic [30:0] mg11_d [3];

  always_comb begin
    mx9_d = mg8_q[0];
    if (mg8_q[1] > mx9_d) mx9_d = mg8_q[1];
    if (mg8_q[2] > mx9_d) mx9_d = mg8_q[2];
  end

  always_comb begin
    pos_d = 6'd0;
    for (int b = 0; b < 63; b++) begin
      if (mx9_q[b]) pos_d = 6'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos10_q >= 6'd30) mg11_d[i] = 31'(mg10_q[i] >> (pos10_q - 6'd30));
      else                  mg11_d[i] = 31'(mg10_q[i] << (6'd30 - pos10_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx9_q   <= mx9_d;
      mg9_q   <= mg8_q;
      sg9_q   <= sg8_q;
      st9_q   <= st8_q;
      pos10_q <= pos_d;
      mg10_q  <= mg9_q;
      sg10_q  <= sg9_q;
      st10_q  <= st9_q;
      mg11_q  <= mg11_d;
      sg11_q  <= sg10_q;
      st11_q  <= st10_q;
    end
  end

  // ------------------------ s12..s13: squared norm of scaled vector
  logic [61:0] sq12_q [3];
  logic [30:0] mg12_q [3];
  logic        sg12_q [3];
  status_e     st12_q;

  logic [63:0] sn_q  [SqrtSteps+1];
  logic [63:0] sr_q  [SqrtSteps+1];
  logic [30:0] smg_q [SqrtSteps+1][3];
  logic        ssg_q [SqrtSteps+1][3];
  status_e     sst_q [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq12_q[i] <= mg11_q[i] * mg11_q[i];
      end
      mg12_q   <= mg11_q;
      sg12_q   <= sg11_q;
      st12_q   <= st11_q;
      sn_q[0]  <= {2'd0, sq12_q[0]} + {2'd0, sq12_q[1]} + {2'd0, sq12_q[2]};
      sr_q[0]  <= '0;
      smg_q[0] <= mg12_q;
      ssg_q[0] <= sg12_q;
      sst_q[0] <= st12_q;
    end
  end

  // ------------------------ integer square root, one result bit per stage
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    logic        take;

    assign trial = sr_q[g] + Bit;
    assign take  = (sn_q[g] >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_q[g+1]  <= take ? (sn_q[g] - trial) : sn_q[g];
        sr_q[g+1]  <= take ? ((sr_q[g] >> 1) + Bit) : (sr_q[g] >> 1);
        smg_q[g+1] <= smg_q[g];
        ssg_q[g+1] <= ssg_q[g];
        sst_q[g+1] <= sst_q[g];
      end
    end
  end

  // ------------------------ numerator with rounding term, then divide
  logic [63:0]         num_q [3];
  logic [31:0]         den_q;
  logic                dsg_q [DivSteps+1][3];
  status_e             dst_q [DivSteps+1];
  logic [DivSteps-1:0] quo [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= ({33'd0, smg_q[SqrtSteps][i]} << 30) + (sr_q[SqrtSteps] >> 1);
      end
      den_q    <= sr_q[SqrtSteps][31:0];
      dsg_q[0] <= ssg_q[SqrtSteps];
      dst_q[0] <= sst_q[SqrtSteps];
      for (int s = 0; s < DivSteps; s++) begin
        dsg_q[s+1] <= dsg_q[s];
        dst_q[s+1] <= dst_q[s];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    evec_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo[i])
    );
  end

  // ------------------------ output register: sign, special cases
  logic signed [31:0] ax_d [3];
  evec_out_t          out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dst_q[DivSteps] != StNormal) ax_d[i] = '0;
      else if (dsg_q[DivSteps][i])     ax_d[i] = -$signed({1'b0, quo[i]});
      else                             ax_d[i] = $signed({1'b0, quo[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.axis_x <= ax_d[0];
      out_q.axis_y <= ax_d[1];
      out_q.axis_z <= ax_d[2];
      out_q.status <= dst_q[DivSteps];
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // special cases carry the zero vector
  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StNormal) |->
      (out_data_o.axis_x == 0 && out_data_o.axis_y == 0 && out_data_o.axis_z == 0))
    else $error("special case with nonzero axis");

  // a unit vector has a component of magnitude above 1/2
  a_unit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == StNormal) |->
      (out_data_o.axis_x >= 32'sd536870912 || out_data_o.axis_x <= -32'sd536870912 ||
       out_data_o.axis_y >= 32'sd536870912 || out_data_o.axis_y <= -32'sd536870912 ||
       out_data_o.axis_z >= 32'sd536870912 || out_data_o.axis_z <= -32'sd536870912))
    else $error("normal result is not unit length");

  // the pipeline only holds behind a stalled result
  a_hold_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("pipeline held without stalled output");
`endif

endmodule

// File: sim/eigenvector_from_eigenvalue_3x3_unit_tb.sv
// Testbench for the 3x3 eigenvector unit: directed and randomized streams checked against a predictor.
module eigenvector_from_eigenvalue_3x3_unit_tb import evec_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdlePct  = 38;
  localparam int DrainCyc = Latency + 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  evec_in_t             in_data_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  evec_out_t            out_data_o;
  logic                 out_stall_i = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  eigenvector_from_eigenvalue_3x3_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the tolerance register
  logic [TolWidth-1:0] tol_q = '0;
  evec_out_t           axis_fifo[$];
  int                  n_err = 0;
  bit                  rx_quiet = 1'b0;  // no random receiver stalls
  int                  rx_hold = 0;      // forced receiver hold-off, in cycles
  bit                  tx_quiet = 1'b0;

  // --- predictor -----------------------------------------------------------

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic evec_out_t predict_axis(input evec_in_t d, input logic [TolWidth-1:0] t);
    logic signed [63:0]  m[9];
    logic signed [63:0]  lm[3][3];
    logic signed [63:0]  c[3][3];
    logic [127:0]        len[3];
    logic [63:0]         mg[3], mx, n2, nrm, q;
    logic [63:0]         tol;
    logic signed [63:0]  ev, v;
    bit                  diag;
    int                  k;
    evec_out_t           r;
    m = '{d.m00, d.m01, d.m02, d.m10, d.m11, d.m12, d.m20, d.m21, d.m22};
    ev = d.eigen_value;
    tol = 64'(t) << (FracBits - 16);
    r = '0;
    diag = 1'b1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (i != j && abs64(m[i*3+j]) > tol) diag = 1'b0;
    if (diag) begin
      r.status = StDiag;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = (i == j) ? m[i*3+j] - ev : m[i*3+j];
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483647) v = -64'sd2147483647;
        lm[i][j] = v;
      end
    for (int p = 0; p < 3; p++) begin
      int a, b;
      a = (p == 2) ? 1 : 0;
      b = (p == 0) ? 1 : 2;
      c[p][0] = lm[a][1]*lm[b][2] - lm[a][2]*lm[b][1];
      c[p][1] = lm[a][2]*lm[b][0] - lm[a][0]*lm[b][2];
      c[p][2] = lm[a][0]*lm[b][1] - lm[a][1]*lm[b][0];
      len[p] = 0;
      for (int i = 0; i < 3; i++) len[p] += 128'(abs64(c[p][i])) * 128'(abs64(c[p][i]));
    end
    if (len[0] >= len[1]) k = (len[0] >= len[2]) ? 0 : 2;
    else                  k = (len[1] >= len[2]) ? 1 : 2;
    if (len[k] == 0) begin
      r.status = StDegen;
      return r;
    end
    for (int i = 0; i < 3; i++) mg[i] = abs64(c[k][i]);
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
    while (mx >= 64'd1 << 31) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (mx < 64'd1 << 30) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    n2 = mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2];
    nrm = root64(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 30) + nrm / 2) / nrm;
      if (c[k][i] < 0) q = -q;
      if (i == 0) r.axis_x = q[31:0];
      else if (i == 1) r.axis_y = q[31:0];
      else r.axis_z = q[31:0];
    end
    r.status = StNormal;
    return r;
  endfunction

  // --- result side ---------------------------------------------------------

  // receiver stall: random, or held during a forced hold-off
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall_i <= !rx_quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    evec_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (axis_fifo.size() == 0) begin
        $error("result with no expectation waiting");
        n_err++;
      end else begin
        exp_r = axis_fifo.pop_front();
        if (out_data_o.axis_x !== exp_r.axis_x) begin
          $error("axis_x expected %0d actual %0d", exp_r.axis_x, out_data_o.axis_x);
          n_err++;
        end
        if (out_data_o.axis_y !== exp_r.axis_y) begin
          $error("axis_y expected %0d actual %0d", exp_r.axis_y, out_data_o.axis_y);
          n_err++;
        end
        if (out_data_o.axis_z !== exp_r.axis_z) begin
          $error("axis_z expected %0d actual %0d", exp_r.axis_z, out_data_o.axis_z);
          n_err++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data_o.status);
          n_err++;
        end
      end
    end
  end

  // --- stimulus helpers ----------------------------------------------------

  // one transfer; keeps valid high when the next item follows at once
  task automatic send_matrix(input evec_in_t d);
    int gap;
    gap = 0;
    if (!tx_quiet) begin
      while ($urandom_range(99) < IdlePct) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    axis_fifo.push_back(predict_axis(d, tol_q));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (axis_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic write_tol(input logic [TolWidth-1:0] t);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'(RegZeroTol) << 2;
    pwdata  <= 32'(t);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_q = t;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      3: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  // random matrix; mode picks symmetric, near diagonal, rank-deficient or raw
  function automatic evec_in_t rnd_matrix();
    evec_in_t d;
    logic [31:0] w[10];
    int sel;
    for (int i = 0; i < 10; i++) w[i] = rnd_word();
    sel = $urandom_range(9);
    if (sel < 4) begin
      w[3] = w[1];
      w[6] = w[2];
      w[7] = w[5];
      if ($urandom_range(1)) w[9] = w[0];
    end else if (sel < 6) begin
      for (int i = 1; i < 8; i++)
        if (i != 4) w[i] = 32'($signed($urandom_range(0, 40)) - 20);
    end else if (sel == 6) begin
      w[3] = w[0]; w[4] = w[1]; w[5] = w[2]; w[9] = 0;  // repeated rows
    end
    d = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9]};
    return d;
  endfunction

  // --- tests ---------------------------------------------------------------

  task automatic test_directed();
    evec_in_t d;
    logic [31:0] s;
    d = '0;
    send_matrix(d);                                       // all zero: diagonal
    d.m00 = 32'h0001_0000; d.m11 = 32'h0002_0000; d.m22 = 32'h0003_0000;
    send_matrix(d);                                       // diagonal
    d.m01 = 1; d.m10 = 1; d.eigen_value = 32'h0001_0000;
    send_matrix(d);                                       // normal
    d = {10{32'h8000_0000}};
    send_matrix(d);
    d = {10{32'h7fff_ffff}};
    send_matrix(d);
    d = {10{32'hffff_ffff}};
    send_matrix(d);
    d = '0; d.m01 = 32'h0001_0000;
    send_matrix(d);                                       // two zero rows: degenerate
    d = {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_matrix(d);                                       // negative saturation, diagonal and off-diagonal
    for (int b = 0; b < 32; b += 4) begin
      s = 32'h1 << b;
      d = {s, s, ~s, s, ~s, s, ~s, s, s, ~s};
      send_matrix(d);
    end
    drain_results();
  endtask

  task automatic test_tolerance();
    logic [TolWidth-1:0] tv[4] = '{16'hffff, 16'h0001, 16'h0014, 16'h8000};
    evec_in_t d;
    foreach (tv[i]) begin
      write_tol(tv[i]);
      d = '0;
      d.m12 = 32'(tv[i]); d.m21 = -32'sd1 * $signed(32'(tv[i]));
      send_matrix(d);                                     // right at the boundary
      d.m12 = 32'(tv[i]) + 1;
      send_matrix(d);                                     // just above it
      for (int n = 0; n < 60; n++) send_matrix(rnd_matrix());
      drain_results();
    end
    write_tol(16'h0000);
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < 1486; n++) begin
      tx_quiet = (n >= 500 && n < 700);
      rx_quiet = (n >= 500 && n < 700);
      send_matrix(rnd_matrix());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    drain_results();
  endtask

  // hold the receiver so the pipeline fills and stalls its input
  task automatic test_backpressure();
    rx_hold = 3 * Latency;
    tx_quiet = 1'b1;
    for (int n = 0; n < 150; n++) send_matrix(rnd_matrix());
    tx_quiet = 1'b0;
    drain_results();                                      // sender pauses until all are back
    for (int n = 0; n < 50; n++) send_matrix(rnd_matrix());
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerance();
    test_random_stream();
    test_backpressure();
    if (n_err == 0 && axis_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      if (axis_fifo.size() != 0) $error("%0d results never arrived", axis_fifo.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
